/* rtl/core/dsdo_pkg.sv */
// ----------------------------------------------------------------------------
// dsdo_pkg
// Shared types and constants for the two-stack store with oldest-entry drop.
// ----------------------------------------------------------------------------
package dsdo_pkg;

	// Default sizing of the shared store.
	localparam int DSDO_DEPTH     = 8;
	localparam int DSDO_WORD_BITS = 32;

	// Fixed width of the request and response value fields.
	localparam int VALUE_BITS = 32;

	// Command codes.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Stack select codes.
	localparam logic SEL_LOW  = 1'b0;
	localparam logic SEL_HIGH = 1'b1;

	// Response status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_DROP      = 2'd1;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

	// Value returned by a pop from an empty stack.
	localparam logic signed [VALUE_BITS-1:0] UNDERFLOW_VALUE = '1;

	// One request.
	typedef struct packed {
		logic                         command;
		logic                         stack_select;
		logic signed [VALUE_BITS-1:0] push_value;
	} req_t;

	// One response.
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] pop_value;
		logic [1:0]                   status;
	} rsp_t;

endpackage

/* rtl/core/dsdo_if.sv */
// ----------------------------------------------------------------------------
// dsdo_req_if / dsdo_rsp_if
// Valid/ready channels that carry requests into and responses out of the block.
// ----------------------------------------------------------------------------
interface dsdo_req_if;
	logic          valid;
	logic          ready;
	dsdo_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dsdo_rsp_if;
	logic          valid;
	logic          ready;
	dsdo_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/dual_stack_drop_oldest.sv */
// ----------------------------------------------------------------------------
// dual_stack_drop_oldest
// Two stacks in one shared store; a push into a full store drops an oldest
// entry, a pop from an empty stack reports underflow.
//
//   channel  direction  payload                                 handshake
//   req      in         command, stack_select, push_value       valid/ready
//   rsp      out        pop_value, status                       valid/ready
//
// Each request goes through the request register and the response register;
// a new request is accepted every cycle unless the response is stalled. The
// request register feeds the store update and the response register in the
// same cycle, so back-to-back requests see each other's effect. Reset empties
// both stacks; store words are not cleared. A stalled response holds the
// request stage, and ready falls only when both stages are full.
// ----------------------------------------------------------------------------
module dual_stack_drop_oldest #(
	parameter int DEPTH     = dsdo_pkg::DSDO_DEPTH,
	parameter int WORD_BITS = dsdo_pkg::DSDO_WORD_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	dsdo_req_if.sink   req,
	dsdo_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	dsdo_pkg::req_t req_s1;
	logic           valid_s1;
	dsdo_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	dsdo_pkg::rsp_t core_rsp;
	logic           advance;
	logic [CW-1:0]  low_count, high_count;

	// The request stage moves on when the response register is free or drains.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	dsdo_core #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.req        (req_s1),
		.rsp        (core_rsp),
		.low_count  (low_count),
		.high_count (high_count)
	);

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) req_s1 <= req.data;
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) rsp_q <= core_rsp;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// The two stacks never hold more entries than the store has.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(low_count) + (CW + 1)'(high_count) <= (CW + 1)'(DEPTH))
		else $error("stack counts exceed the store depth");

	// An underflow response always carries the underflow value.
	a_underflow_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.data.status == dsdo_pkg::STATUS_UNDERFLOW)
		|-> (rsp.data.pop_value == dsdo_pkg::UNDERFLOW_VALUE))
		else $error("underflow response without the underflow value");

	// A request leaving the first stage is presented as a response next cycle.
	a_advance_presents: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("processed request did not produce a response");

endmodule

/* rtl/core/dsdo_core.sv */
// ----------------------------------------------------------------------------
// dsdo_core
// Shared word store and the two stack counts. Applies one request per enabled
// cycle and produces its response combinationally.
// ----------------------------------------------------------------------------
module dsdo_core #(
	parameter int DEPTH     = dsdo_pkg::DSDO_DEPTH,
	parameter int WORD_BITS = dsdo_pkg::DSDO_WORD_BITS,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int IW = $clog2(DEPTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  dsdo_pkg::req_t req,
	output dsdo_pkg::rsp_t rsp,
	output logic [CW-1:0]  low_count,
	output logic [CW-1:0]  high_count
);

	localparam int VB = dsdo_pkg::VALUE_BITS;

	logic [WORD_BITS-1:0] store_q [DEPTH];
	logic [WORD_BITS-1:0] store_d [DEPTH];
	logic [CW-1:0]        low_q, high_q, low_d, high_d;

	logic [WORD_BITS-1:0] push_word;
	logic [WORD_BITS-1:0] rd_word;
	logic [VB-1:0]        rd_value;
	logic [CW-1:0]        rd_addr_w;
	logic [IW-1:0]        rd_addr;
	logic [CW-1:0]        wr_addr_w;
	logic                 is_push, is_low, full, low_empty, high_empty;
	logic                 push_room, drop_up, shift_low, drop_down, shift_high;

	// Fit the pushed value into a store word and a store word into the response.
	if (WORD_BITS < VB) begin : g_narrow
		assign push_word = req.push_value[WORD_BITS-1:0];
		assign rd_value  = {{(VB - WORD_BITS){1'b0}}, rd_word};
	end else if (WORD_BITS == VB) begin : g_equal
		assign push_word = req.push_value;
		assign rd_value  = rd_word;
	end else begin : g_wide
		assign push_word = {{(WORD_BITS - VB){1'b0}}, req.push_value};
		assign rd_value  = rd_word[VB-1:0];
	end

	// Decode the request against the current fill state.
	assign is_push    = (req.command == dsdo_pkg::CMD_PUSH);
	assign is_low     = (req.stack_select == dsdo_pkg::SEL_LOW);
	assign full       = (CW'(low_q + high_q) == CW'(DEPTH));
	assign low_empty  = (low_q == '0);
	assign high_empty = (high_q == '0);

	assign push_room  = is_push && !full;
	assign drop_up    = is_push && full && is_low && low_empty;
	assign shift_low  = is_push && full && is_low && !low_empty;
	assign drop_down  = is_push && full && !is_low && high_empty;
	assign shift_high = is_push && full && !is_low && !high_empty;

	// Write slot of a push into free space, and top slot of the selected stack.
	assign wr_addr_w = is_low ? low_q : CW'(DEPTH - 1) - high_q;
	assign rd_addr_w = is_low ? low_q - CW'(1) : CW'(DEPTH) - high_q;
	assign rd_addr   = rd_addr_w[IW-1:0];
	assign rd_word   = store_q[rd_addr];

	// Next value of every entry, computed independently per slot.
	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		logic [WORD_BITS-1:0] from_below, from_above;

		if (i == 0) begin : g_first
			assign from_below = push_word;
		end else begin : g_below
			assign from_below = store_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign from_above = push_word;
		end else begin : g_above
			assign from_above = store_q[i+1];
		end

		always_comb begin
			store_d[i] = store_q[i];
			if (push_room) begin
				if (wr_addr_w == CW'(i)) store_d[i] = push_word;
			end else if (drop_up) begin
				store_d[i] = (i == 0) ? push_word : from_below;
			end else if (drop_down) begin
				store_d[i] = (i == DEPTH - 1) ? push_word : from_above;
			end else if (shift_low) begin
				if (CW'(i) == low_q - CW'(1)) store_d[i] = push_word;
				else if (CW'(i) < low_q) store_d[i] = from_above;
			end else if (shift_high) begin
				if (CW'(i) == CW'(DEPTH) - high_q) store_d[i] = push_word;
				else if (CW'(i) > CW'(DEPTH) - high_q) store_d[i] = from_below;
			end
		end
	end

	// Next counts and the response.
	always_comb begin
		low_d  = low_q;
		high_d = high_q;
		rsp.pop_value = '0;
		rsp.status    = dsdo_pkg::STATUS_OK;
		if (is_push) begin
			if (!full) begin
				if (is_low) low_d = low_q + CW'(1);
				else        high_d = high_q + CW'(1);
			end else begin
				rsp.status = dsdo_pkg::STATUS_DROP;
				if (drop_up) begin
					low_d = CW'(1);
					if (!high_empty) high_d = high_q - CW'(1);
				end else if (drop_down) begin
					high_d = CW'(1);
					if (!low_empty) low_d = low_q - CW'(1);
				end
			end
		end else if ((is_low && low_empty) || (!is_low && high_empty)) begin
			rsp.pop_value = dsdo_pkg::UNDERFLOW_VALUE;
			rsp.status    = dsdo_pkg::STATUS_UNDERFLOW;
		end else begin
			rsp.pop_value = rd_value;
			if (is_low) low_d = low_q - CW'(1);
			else        high_d = high_q - CW'(1);
		end
	end

	// Store words hold payload only and need no reset.
	always_ff @(posedge clk) begin
		if (en) store_q <= store_d;
	end

	// Stack counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (en) begin
			low_q  <= low_d;
			high_q <= high_d;
		end
	end

	assign low_count  = low_q;
	assign high_count = high_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-stack store with oldest-entry drop. A short
// table of requests covers the field extremes, underflow on either stack and
// both kinds of drop on a full store. Weighted random traffic follows. Every
// response is compared against a cycle-free model of the two stacks, or
// against the hand-typed response of a fixed table row, with random idle
// bursts on both channels, one long response stall and one drain pause.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 1130;
	localparam int LONG_HOLD_CYCLES = 48;
	localparam int HOLD_AT = 400;
	localparam int DRAIN_AT = 700;
	localparam int CALM_AT = 980;
	localparam int DRAIN_LIMIT = 2000;
	localparam int TAIL_CYCLES = 10;

	typedef logic [dsdo_pkg::DSDO_WORD_BITS-1:0] stack_word_t;

	// One row of the directed table: the request and, where fixed is set,
	// the response typed in by hand.
	typedef struct packed {
		dsdo_pkg::req_t req;
		logic           fixed;
		dsdo_pkg::rsp_t rsp;
	} plan_row_t;

	logic clk;
	logic arst_n;

	dsdo_req_if req_ch ();
	dsdo_rsp_if rsp_ch ();

	dual_stack_drop_oldest u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Model state of the two stacks.
	stack_word_t stack_words [dsdo_pkg::DSDO_DEPTH];
	int low_fill;
	int high_fill;

	dsdo_pkg::rsp_t pending_rsp [$];
	plan_row_t directed [$];

	int mismatches;
	int push_count;
	int pop_count;
	int drop_count;
	int underflow_count;

	bit calm;
	bit long_hold_req;
	bit hold_active;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Known values on every input from time zero; reset is held low, then released.
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Overall time limit.
	initial begin
		#2_000_000;
		$display("dual_stack_drop_oldest: mismatch");
		$finish;
	end

	function automatic dsdo_pkg::req_t mk_req(logic cmd, logic sel,
		logic signed [dsdo_pkg::VALUE_BITS-1:0] val);
		dsdo_pkg::req_t r;
		r.command = cmd;
		r.stack_select = sel;
		r.push_value = val;
		return r;
	endfunction

	// Applies one request to the model stacks and returns its response.
	function automatic dsdo_pkg::rsp_t predict_response(dsdo_pkg::req_t r);
		dsdo_pkg::rsp_t res;
		stack_word_t w;
		int i;
		int top;
		res.pop_value = '0;
		res.status = dsdo_pkg::STATUS_OK;
		w = stack_word_t'(r.push_value);
		if (r.command == dsdo_pkg::CMD_PUSH) begin
			if (low_fill + high_fill >= dsdo_pkg::DSDO_DEPTH) begin
				res.status = dsdo_pkg::STATUS_DROP;
				if (r.stack_select == dsdo_pkg::SEL_LOW) begin
					if (low_fill == 0) begin
						// The upper stack loses its bottom at the high end.
						for (i = dsdo_pkg::DSDO_DEPTH - 1; i > 0; i--) begin
							stack_words[i] = stack_words[i - 1];
						end
						if (high_fill > 0) begin
							high_fill--;
						end
						low_fill = 1;
						stack_words[0] = w;
					end else begin
						for (i = 0; i + 1 < low_fill; i++) begin
							stack_words[i] = stack_words[i + 1];
						end
						stack_words[low_fill - 1] = w;
					end
				end else begin
					if (high_fill == 0) begin
						// The lower stack loses its bottom at the low end.
						for (i = 0; i + 1 < dsdo_pkg::DSDO_DEPTH; i++) begin
							stack_words[i] = stack_words[i + 1];
						end
						if (low_fill > 0) begin
							low_fill--;
						end
						high_fill = 1;
						stack_words[dsdo_pkg::DSDO_DEPTH - 1] = w;
					end else begin
						top = dsdo_pkg::DSDO_DEPTH - high_fill;
						for (i = dsdo_pkg::DSDO_DEPTH - 1; i > top; i--) begin
							stack_words[i] = stack_words[i - 1];
						end
						stack_words[top] = w;
					end
				end
			end else if (r.stack_select == dsdo_pkg::SEL_LOW) begin
				stack_words[low_fill] = w;
				low_fill++;
			end else begin
				high_fill++;
				stack_words[dsdo_pkg::DSDO_DEPTH - high_fill] = w;
			end
		end else begin
			if (r.stack_select == dsdo_pkg::SEL_LOW) begin
				if (low_fill == 0) begin
					res.pop_value = dsdo_pkg::UNDERFLOW_VALUE;
					res.status = dsdo_pkg::STATUS_UNDERFLOW;
				end else begin
					low_fill--;
					res.pop_value = dsdo_pkg::VALUE_BITS'(stack_words[low_fill]);
				end
			end else begin
				if (high_fill == 0) begin
					res.pop_value = dsdo_pkg::UNDERFLOW_VALUE;
					res.status = dsdo_pkg::STATUS_UNDERFLOW;
				end else begin
					res.pop_value = dsdo_pkg::VALUE_BITS'(
						stack_words[dsdo_pkg::DSDO_DEPTH - high_fill]);
					high_fill--;
				end
			end
		end
		return res;
	endfunction

	// Offers one request, waits for it to be taken, then records the response
	// it must produce.
	task automatic offer_request(dsdo_pkg::req_t r, logic fixed,
		dsdo_pkg::rsp_t fixed_rsp);
		dsdo_pkg::rsp_t res;
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		res = predict_response(r);
		if (r.command == dsdo_pkg::CMD_PUSH) begin
			push_count++;
		end else begin
			pop_count++;
		end
		if (res.status == dsdo_pkg::STATUS_DROP) begin
			drop_count++;
		end
		if (res.status == dsdo_pkg::STATUS_UNDERFLOW) begin
			underflow_count++;
		end
		pending_rsp.push_back(fixed ? fixed_rsp : res);
	endtask

	// Random idle burst on the request side, skipped in the calm tail and
	// while the response side is held off.
	task automatic sender_gap();
		if (!calm && !long_hold_req && !hold_active &&
		    $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Response ready: random stall bursts, one long hold on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_active = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Response checker: each accepted response against the oldest expectation.
	always @(posedge clk) begin : rsp_check
		dsdo_pkg::rsp_t exp_rsp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected response: pop_value %h status %0d",
						rsp_ch.data.pop_value, rsp_ch.data.status);
				end
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp_ch.data.pop_value !== exp_rsp.pop_value ||
				    rsp_ch.data.status !== exp_rsp.status) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display({"response mismatch: pop_value expected %h got %h,",
							" status expected %0d got %0d"},
							exp_rsp.pop_value, rsp_ch.data.pop_value,
							exp_rsp.status, rsp_ch.data.status);
					end
				end
			end
		end
	end

	// Main sequence.
	initial begin : main_seq
		dsdo_pkg::req_t r;
		int push_pct;
		int sel_mode;
		int wait_cycles;
		logic cmd;
		logic sel;
		logic signed [dsdo_pkg::VALUE_BITS-1:0] val;
		dsdo_pkg::rsp_t ok_push;
		dsdo_pkg::rsp_t drop_push;
		dsdo_pkg::rsp_t underflow;

		low_fill = 0;
		high_fill = 0;
		mismatches = 0;
		push_count = 0;
		pop_count = 0;
		drop_count = 0;
		underflow_count = 0;
		calm = 1'b0;
		long_hold_req = 1'b0;
		hold_active = 1'b0;
		ok_push = '{pop_value: '0, status: dsdo_pkg::STATUS_OK};
		drop_push = '{pop_value: '0, status: dsdo_pkg::STATUS_DROP};
		underflow = '{pop_value: dsdo_pkg::UNDERFLOW_VALUE,
			status: dsdo_pkg::STATUS_UNDERFLOW};

		// Directed table: empty stacks, value extremes, a full store, and
		// both kinds of drop.
		directed.push_back('{mk_req(dsdo_pkg::CMD_POP, dsdo_pkg::SEL_LOW, 32'sd0),
			1'b1, underflow});
		directed.push_back('{mk_req(dsdo_pkg::CMD_POP, dsdo_pkg::SEL_HIGH, 32'sd0),
			1'b1, underflow});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_LOW,
			32'sh7fffffff), 1'b1, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_HIGH,
			32'sh80000000), 1'b1, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_POP, dsdo_pkg::SEL_HIGH,
			32'shffffffff), 1'b1,
			'{pop_value: 32'sh80000000, status: dsdo_pkg::STATUS_OK}});
		directed.push_back('{mk_req(dsdo_pkg::CMD_POP, dsdo_pkg::SEL_LOW, 32'sh0),
			1'b1, '{pop_value: 32'sh7fffffff, status: dsdo_pkg::STATUS_OK}});
		directed.push_back('{mk_req(dsdo_pkg::CMD_POP, dsdo_pkg::SEL_LOW, 32'sh0),
			1'b1, underflow});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_LOW, 32'sh0),
			1'b0, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_LOW,
			32'shffffffff), 1'b0, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_LOW, 32'sh1),
			1'b0, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_LOW, 32'sh2),
			1'b0, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_LOW, 32'sh3),
			1'b0, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_LOW, 32'sh4),
			1'b0, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_LOW, 32'sh5),
			1'b0, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_LOW, 32'sh6),
			1'b0, ok_push});
		// The store is now full with the upper stack empty.
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_LOW,
			32'sh55555555), 1'b1, drop_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_HIGH,
			32'shaaaaaaaa), 1'b1, drop_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_PUSH, dsdo_pkg::SEL_HIGH,
			32'sh12345678), 1'b1, drop_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_POP, dsdo_pkg::SEL_HIGH, 32'sh0),
			1'b0, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_POP, dsdo_pkg::SEL_HIGH, 32'sh0),
			1'b1, underflow});
		directed.push_back('{mk_req(dsdo_pkg::CMD_POP, dsdo_pkg::SEL_LOW, 32'sh0),
			1'b0, ok_push});
		directed.push_back('{mk_req(dsdo_pkg::CMD_POP, dsdo_pkg::SEL_LOW, 32'sh0),
			1'b0, ok_push});

		@(posedge arst_n);
		@(posedge clk);

		foreach (directed[k]) begin
			offer_request(directed[k].req, directed[k].fixed, directed[k].rsp);
			sender_gap();
		end

		// Random traffic in blocks of 40 with a changing push rate and stack bias,
		// so the store fills, drains and runs full with one stack empty.
		push_pct = 50;
		sel_mode = 2;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 4))
					0: push_pct = 15;
					1: push_pct = 50;
					2: push_pct = 70;
					3: push_pct = 90;
					default: push_pct = 100;
				endcase
				sel_mode = $urandom_range(0, 3);
			end
			if (n == HOLD_AT) begin
				long_hold_req = 1'b1;
			end
			if (n == DRAIN_AT) begin
				// Pause the sender until every response has come back.
				req_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_rsp.size() != 0) @(posedge clk);
			end
			if (n == CALM_AT) begin
				calm = 1'b1;
			end
			cmd = ($urandom_range(0, 99) < push_pct) ? dsdo_pkg::CMD_PUSH
				: dsdo_pkg::CMD_POP;
			case (sel_mode)
				0: sel = dsdo_pkg::SEL_LOW;
				1: sel = dsdo_pkg::SEL_HIGH;
				2: sel = 1'($urandom_range(0, 1));
				default: sel = ($urandom_range(0, 4) == 0) ? dsdo_pkg::SEL_HIGH
					: dsdo_pkg::SEL_LOW;
			endcase
			case ($urandom_range(0, 19))
				0: val = 32'sh7fffffff;
				1: val = 32'sh80000000;
				2: val = 32'sh0;
				3: val = 32'shffffffff;
				default: val = $urandom;
			endcase
			r = mk_req(cmd, sel, val);
			offer_request(r, 1'b0, ok_push);
			sender_gap();
		end
		req_ch.valid <= 1'b0;

		// Drain, then let the pipeline settle.
		wait_cycles = 0;
		while (pending_rsp.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$display("%0d responses never arrived", pending_rsp.size());
			mismatches++;
		end

		$display("Ran %0d requests: %0d pushes, %0d pops.", push_count + pop_count,
			push_count, pop_count);
		$display("Saw %0d drops on a full store and %0d underflow pops; %0d mismatches.",
			drop_count, underflow_count, mismatches);
		if (mismatches == 0) begin
			$display("dual_stack_drop_oldest: match");
		end else begin
			$display("dual_stack_drop_oldest: mismatch");
		end
		$finish;
	end

endmodule

/* dual_stack_drop_oldest.f */
rtl/core/dsdo_pkg.sv
rtl/core/dsdo_if.sv
rtl/core/dsdo_core.sv
rtl/core/dual_stack_drop_oldest.sv
tb/testbench.sv
